### hw/rtl/bitmap_block_allocator_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the bitmap block allocator
// Shared forms for concurrent checks, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef BITMAP_BLOCK_ALLOCATOR_ASSERT_SVH
`define BITMAP_BLOCK_ALLOCATOR_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BBA_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bitmap_block_allocator: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define BBA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bitmap_block_allocator: next-cycle check failed");

`endif

### hw/rtl/bba_pkg.sv
// ----------------------------------------------------------------------------
// bba_pkg
// Sizes, codes and state encoding for the bitmap block allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

    localparam int unsigned MAX_BLOCKS = 4096;
    localparam int unsigned WORD_BITS  = 64;
    localparam int unsigned WORD_COUNT = MAX_BLOCKS / WORD_BITS;
    localparam int unsigned ADDR_W     = $clog2(WORD_COUNT);
    localparam int unsigned BIT_W      = $clog2(WORD_BITS);
    localparam int unsigned BLK_W      = 12;
    localparam int unsigned TOTAL_W    = 13;
    localparam int unsigned LWORD_W    = TOTAL_W - BIT_W;

    typedef enum logic
    {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } cmd_t;

    typedef enum logic [1:0]
    {
        ST_OK            = 2'd0,
        ST_OUT_OF_BLOCKS = 2'd1,
        ST_DOUBLE_FREE   = 2'd2,
        ST_OUT_OF_RANGE  = 2'd3
    } status_t;

    typedef enum logic [2:0]
    {
        S_IDLE,
        S_FREE_CHK,
        S_SCAN,
        S_DONE
    } state_t;

endpackage

### hw/rtl/bba_ram.sv
// ----------------------------------------------------------------------------
// bba_ram
// Generic single-clock RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module bba_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/bitmap_block_allocator.sv
// ----------------------------------------------------------------------------
// bitmap_block_allocator
// First-fit block allocator over a used-bit map held in one 64 x 64 RAM.
//
// Command channel (cmd_valid/cmd_ready): command 0 allocates the lowest free
// block below the configured total, command 1 frees block_number.
// Response channel (rsp_valid/rsp_ready): allocated_block and status, one
// response per command, in order.
// cfg_write_en/cfg_write_data set total_blocks; write only while idle.
// A free reads the word that holds the block, checks its bit and clears it if
// set; a block out of range goes straight to the done state. An allocate reads
// one bitmap word per cycle, until the word that holds the grant or the last
// word below the total; a zero total goes straight to the done state.
// One command is in flight at a time; the next is taken as soon as the
// previous response sits in the output register.
// Reset clears the map at once through per-word valid bits (a word not yet
// written reads as all free) and sets total_blocks to 4096.
// A stalled receiver holds the response register; a finished command then
// waits in the done state, and no further command is taken.
// ----------------------------------------------------------------------------
module bitmap_block_allocator (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_write_en,
    input  logic [bba_pkg::TOTAL_W-1:0]  cfg_write_data,
    input  logic                         cmd_valid,
    output logic                         cmd_ready,
    input  logic                         command,
    input  logic [bba_pkg::BLK_W-1:0]    block_number,
    output logic                         rsp_valid,
    input  logic                         rsp_ready,
    output logic [bba_pkg::BLK_W-1:0]    allocated_block,
    output logic [1:0]                   status
);

    import bba_pkg::*;

    `include "bitmap_block_allocator_assert.svh"

    // control state
    state_t                state_reg;
    state_t                state_next;
    logic [TOTAL_W-1:0]    total_reg;
    logic [WORD_COUNT-1:0] valid_row_reg;
    logic                  rsp_valid_reg;

    // datapath state
    logic [ADDR_W-1:0]     scan_idx_reg;
    logic [ADDR_W-1:0]     scan_idx_next;
    logic [BLK_W-1:0]      blk_reg;
    logic                  rd_valid_reg;
    logic [BLK_W-1:0]      res_block_reg;
    logic [BLK_W-1:0]      res_block_next;
    status_t               res_status_reg;
    status_t               res_status_next;
    logic [BLK_W-1:0]      rsp_block_reg;
    status_t               rsp_status_reg;

    // RAM ports
    logic                  ram_we;
    logic [ADDR_W-1:0]     ram_waddr;
    logic [WORD_BITS-1:0]  ram_wdata;
    logic                  ram_re;
    logic [ADDR_W-1:0]     ram_raddr;
    logic [WORD_BITS-1:0]  ram_rdata;

    // derived
    logic                  cmd_xfer;
    logic                  rsp_load;
    logic [TOTAL_W-1:0]    lim;
    logic [LWORD_W-1:0]    lim_word;
    logic [BIT_W-1:0]      lim_bit;
    logic [WORD_BITS-1:0]  occupied;
    logic [WORD_BITS-1:0]  scan_mask;
    logic [WORD_BITS-1:0]  cand;
    logic                  found;
    logic [BIT_W-1:0]      found_idx;
    logic                  last_word;
    logic                  free_out_of_range;
    logic                  free_bit;

    bba_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (WORD_COUNT)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign cmd_ready = (state_reg == S_IDLE);
    assign cmd_xfer  = cmd_valid && cmd_ready;
    assign rsp_load  = (state_reg == S_DONE) && (!rsp_valid_reg || rsp_ready);

    // Clamp the total to the map size.
    assign lim      = (total_reg > TOTAL_W'(MAX_BLOCKS)) ? TOTAL_W'(MAX_BLOCKS) : total_reg;
    assign lim_word = lim[TOTAL_W-1:BIT_W];
    assign lim_bit  = lim[BIT_W-1:0];

    assign free_out_of_range = ({1'b0, block_number} >= lim);

    // A word never written since reset reads as all free.
    assign occupied = rd_valid_reg ? ram_rdata : '0;

    // Keep only bits below the limit in the word under scan.
    always_comb
    begin
        if (LWORD_W'(scan_idx_reg) < lim_word)
        begin
            scan_mask = '1;
        end
        else
        begin
            scan_mask = (WORD_BITS'(1) << lim_bit) - WORD_BITS'(1);
        end
    end

    assign cand  = ~occupied & scan_mask;
    assign found = |cand;

    // Lowest clear bit wins.
    always_comb
    begin
        found_idx = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (cand[i])
            begin
                found_idx = BIT_W'(i);
            end
        end
    end

    assign last_word = ((LWORD_W'(scan_idx_reg) + LWORD_W'(1) == lim_word) && (lim_bit == '0))
                    || (LWORD_W'(scan_idx_reg) == lim_word);

    assign free_bit = occupied[blk_reg[BIT_W-1:0]];

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd_xfer)
                begin
                    if (command == CMD_FREE)
                    begin
                        state_next = free_out_of_range ? S_DONE : S_FREE_CHK;
                    end
                    else
                    begin
                        state_next = (lim == '0) ? S_DONE : S_SCAN;
                    end
                end
            end
            S_FREE_CHK:
            begin
                state_next = S_DONE;
            end
            S_SCAN:
            begin
                if (found || last_word)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (rsp_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Outputs: RAM accesses and result capture
    always_comb
    begin
        ram_we          = 1'b0;
        ram_waddr       = scan_idx_reg;
        ram_wdata       = '0;
        ram_re          = 1'b0;
        ram_raddr       = '0;
        scan_idx_next   = scan_idx_reg;
        res_block_next  = res_block_reg;
        res_status_next = res_status_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd_xfer)
                begin
                    ram_re         = 1'b1;
                    scan_idx_next  = '0;
                    res_block_next = '0;
                    if (command == CMD_FREE)
                    begin
                        ram_raddr       = block_number[BLK_W-1:BIT_W];
                        res_status_next = ST_OUT_OF_RANGE;
                    end
                    else
                    begin
                        ram_raddr       = '0;
                        res_status_next = ST_OUT_OF_BLOCKS;
                    end
                end
            end
            S_FREE_CHK:
            begin
                ram_waddr = blk_reg[BLK_W-1:BIT_W];
                if (free_bit)
                begin
                    ram_we          = 1'b1;
                    ram_wdata       = occupied & ~(WORD_BITS'(1) << blk_reg[BIT_W-1:0]);
                    res_status_next = ST_OK;
                end
                else
                begin
                    res_status_next = ST_DOUBLE_FREE;
                end
            end
            S_SCAN:
            begin
                // Read the following word ahead while this one is checked.
                ram_re        = 1'b1;
                ram_raddr     = scan_idx_reg + ADDR_W'(1);
                scan_idx_next = scan_idx_reg + ADDR_W'(1);
                if (found)
                begin
                    ram_we          = 1'b1;
                    ram_wdata       = occupied | (WORD_BITS'(1) << found_idx);
                    res_block_next  = {scan_idx_reg, found_idx};
                    res_status_next = ST_OK;
                end
                else if (last_word)
                begin
                    res_status_next = ST_OUT_OF_BLOCKS;
                end
            end
            S_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            total_reg     <= TOTAL_W'(MAX_BLOCKS);
            valid_row_reg <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_write_en)
            begin
                total_reg <= cfg_write_data;
            end
            if (ram_we)
            begin
                valid_row_reg[ram_waddr] <= 1'b1;
            end
            if (rsp_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        scan_idx_reg   <= scan_idx_next;
        res_block_reg  <= res_block_next;
        res_status_reg <= res_status_next;
        if (cmd_xfer)
        begin
            blk_reg <= block_number;
        end
        if (ram_re)
        begin
            rd_valid_reg <= valid_row_reg[ram_raddr];
        end
        if (rsp_load)
        begin
            rsp_block_reg  <= res_block_reg;
            rsp_status_reg <= res_status_reg;
        end
    end

    assign rsp_valid       = rsp_valid_reg;
    assign allocated_block = rsp_block_reg;
    assign status          = rsp_status_reg;

    // Checks
    `BBA_ASSERT_NEXT(a_busy_after_xfer, cmd_xfer, state_reg != S_IDLE)
    `BBA_ASSERT_NOW(a_write_state, ram_we, (state_reg == S_FREE_CHK) || (state_reg == S_SCAN))
    `BBA_ASSERT_NOW(a_fail_no_block, rsp_valid_reg && (rsp_status_reg != ST_OK), rsp_block_reg == '0)

endmodule
